// File: sv/segu_pkg.sv
// Shared types and codes for the sound envelope generator.
package segu_pkg;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_INT_TICK = 2'd1,
    OP_EXT_TICK = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  localparam logic [7:0] CtlEnable  = 8'h80;
  localparam logic [7:0] CtlExtClk  = 8'h20;
  localparam logic [7:0] CtlThreeBit = 8'h10;
  localparam logic [3:0] LevelTop4  = 4'd15;
  localparam logic [3:0] LevelTop3  = 4'd14;
  localparam logic [3:0] LastStep   = 4'd15;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] control_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0] left_level;
    logic [3:0] right_level;
    logic       active;
  } out_item_t;

  typedef struct packed {
    logic       enabled;
    logic       ok_for_new;
    logic       pending_valid;
    logic [7:0] pending_byte;
    logic       ended;
    logic       phase_index;
    logic [3:0] step_position;
    logic [2:0] waveform_sel;
    logic       three_bit_mode;
    logic       invert_right;
    logic       external_clock;
    logic [3:0] left_reg;
    logic [3:0] right_reg;
  } env_state_t;

endpackage

// File: sv/sound_envelope_generator_unit.sv
// Top level of the sound envelope generator: handshake and result register.
// The result of an item is registered and offered in the cycle after it is accepted.
// Throughput: one item per cycle while the output is not stalled; the state update is a single registered step.
// A new item is taken whenever the result register is empty or being drained.
// Reset (rst_ni low, asynchronous) disables the envelope, marks it ended
// and clears all levels and the pending control byte.
module sound_envelope_generator_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  segu_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output segu_pkg::out_item_t out_data_o
);
  import segu_pkg::*;

  logic      accept;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, res;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  segu_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .result_o (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/segu_core.sv
// Envelope state register and per-item update logic.
module segu_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  segu_pkg::in_item_t  item_i,
  output segu_pkg::out_item_t result_o
);
  import segu_pkg::*;

  localparam env_state_t StReset = '{ended: 1'b1, default: '0};

  env_state_t st_q, st_d;

  function automatic logic [3:0] level4(logic [2:0] w, logic ph, logic [3:0] p);
    logic [3:0] l;
    unique case (w)
      3'd0:       l = 4'd0;
      3'd1:       l = 4'd15;
      3'd2, 3'd3: l = ph ? 4'd0 : (LevelTop4 - p);
      3'd4, 3'd5: l = ph ? (LevelTop4 - p) : p;
      default:    l = ph ? 4'd0 : p;
    endcase
    return l;
  endfunction

  function automatic env_state_t upd_levels(env_state_t s);
    env_state_t r;
    logic [3:0] l;
    logic [3:0] top;
    r   = s;
    l   = level4(s.waveform_sel, s.phase_index, s.step_position);
    top = s.three_bit_mode ? LevelTop3 : LevelTop4;
    if (s.three_bit_mode) l = l & 4'd14;
    r.left_reg  = l;
    r.right_reg = s.invert_right ? (top - l) : l;
    return r;
  endfunction

  function automatic env_state_t load_byte(env_state_t s, logic [7:0] b);
    env_state_t r;
    r = s;
    r.phase_index    = 1'b0;
    r.step_position  = 4'd0;
    r.waveform_sel   = b[3:1];
    r.invert_right   = b[0];
    r.external_clock = |(b & CtlExtClk);
    r.three_bit_mode = |(b & CtlThreeBit);
    r.enabled        = |(b & CtlEnable);
    r.ended          = ~r.enabled;
    return upd_levels(r);
  endfunction

  function automatic env_state_t do_tick(env_state_t s);
    env_state_t r;
    logic       two_ph;
    logic [4:0] pos;
    r      = s;
    two_ph = (s.waveform_sel == 3'd4) || (s.waveform_sel == 3'd5);
    pos    = {1'b0, s.step_position} + (s.three_bit_mode ? 5'd2 : 5'd1);
    if (s.ended) begin
      r.phase_index   = two_ph;
      r.step_position = LastStep;
      r.ok_for_new    = 1'b1;
    end else begin
      if (pos[4]) begin
        r.step_position = pos[3:0];
        if (s.phase_index || !two_ph) begin
          r.ok_for_new = 1'b1;
          if (!s.waveform_sel[0]) begin
            r.ended         = 1'b1;
            r.phase_index   = two_ph;
            r.step_position = LastStep;
          end else begin
            r.phase_index = 1'b0;
          end
        end else begin
          r.phase_index = 1'b1;
          r.ok_for_new  = 1'b0;
        end
      end else begin
        r.step_position = pos[3:0];
        r.ok_for_new    = 1'b0;
      end
      if (r.pending_valid && r.ok_for_new) begin
        r.pending_valid = 1'b0;
        r.ok_for_new    = 1'b0;
        r = load_byte(r, r.pending_byte);
      end else begin
        r = upd_levels(r);
      end
    end
    return r;
  endfunction

  function automatic env_state_t do_write(env_state_t s, logic [7:0] b);
    env_state_t r;
    r = s;
    r.three_bit_mode = |(b & CtlThreeBit);
    r.enabled        = |(b & CtlEnable);
    if (!r.enabled) begin
      r.phase_index   = 1'b0;
      r.step_position = 4'd0;
      r.ended         = 1'b1;
      r.ok_for_new    = 1'b1;
      r.pending_valid = 1'b1;
      r.pending_byte  = b;
      r = upd_levels(r);
    end else if (r.ok_for_new) begin
      r = load_byte(r, b);
      r.pending_valid = 1'b0;
      r.ok_for_new    = 1'b0;
    end else begin
      r = upd_levels(r);
      r.pending_valid = 1'b1;
      r.pending_byte  = b;
    end
    return r;
  endfunction

  always_comb begin
    st_d = st_q;
    if (accept_i) begin
      unique case (op_e'(item_i.op))
        OP_WRITE: st_d = do_write(st_q, item_i.control_byte);
        OP_INT_TICK: begin
          if (st_q.enabled && !st_q.external_clock) st_d = do_tick(st_q);
        end
        OP_EXT_TICK: begin
          if (st_q.enabled && st_q.external_clock) st_d = do_tick(st_q);
        end
        OP_NONE: st_d = st_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StReset;
    end else begin
      st_q <= st_d;
    end
  end

  assign result_o.left_level  = st_d.left_reg;
  assign result_o.right_level = st_d.right_reg;
  assign result_o.active      = st_d.enabled;

endmodule
